FILE: design/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority queue package
// Shared constants, result codes and the decision record that is passed from
// the queue controller to the output stage.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_CLASS_DEF    = 7;
	localparam int CLASS_DEPTH_DEF  = 64;
	localparam int HANDLE_WIDTH_DEF = 16;

	// Fixed field widths of the request and result items.
	localparam int FLOW_W   = 16;
	localparam int HDL_W    = 16;
	localparam int STATUS_W = 3;
	localparam int CLS_W    = 3;
	localparam int NCLS_W   = 3;
	localparam int LIMIT_W  = 7;
	localparam int TOTAL_W  = 7;

	// Flow id to class mapping: ids above ID_SPLIT are divided by ID_DIV.
	localparam int ID_SPLIT = 999;
	localparam int ID_DIV   = 1000;

	// Configuration register indexes and reset values.
	localparam logic CFG_NUM_CLASSES = 1'b0;
	localparam logic CFG_QUEUE_LIMIT = 1'b1;
	localparam logic [NCLS_W-1:0]  NUM_CLASSES_RST = '0;
	localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST = 7'd50;

	// Request kinds.
	localparam logic REQ_ENQUEUE = 1'b0;
	localparam logic REQ_DEQUEUE = 1'b1;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_ENQUEUED = 3'd0,
		ST_DROPPED  = 3'd1,
		ST_PUSHOUT  = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Source of the reported handle.
	typedef enum logic [1:0] {
		HS_ZERO    = 2'd0,
		HS_ARRIVAL = 2'd1,
		HS_STORE   = 2'd2
	} hsel_t;

	// Outcome of one request, carried to the result stage.
	typedef struct packed {
		status_t           status;
		hsel_t             hsel;
		logic [CLS_W-1:0]  cls;
	} dec_t;

endpackage

FILE: design/strict_priority_queue_pushout_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Strict priority queue with push-out
// Multi-class descriptor queue with a shared occupancy limit. Enqueues either
// place the arrival, push out the tail of a lower class, or drop the arrival;
// dequeues serve classes 1 and up in order, then class 0.
//
// Channel  Direction  Transfer contents
// s_*      in         tuser: req_type; tdata: flow_id, pkt_handle
// m_*      out        tuser: status; tdata: out_handle, out_class
// cfg_*    in         register write, index 0 num_classes, 1 queue_limit
//
// One request is taken per cycle while the result is not stalled. A request
// moves from the input register, with its decision and store read, into the
// result register, which the store's registered read port loads alongside.
// Reset clears the counters at once; the descriptor store is not cleared.
// A stalled result holds the result register and backs up the input register.
// ----------------------------------------------------------------------------
module strict_priority_queue_pushout_core #(
	parameter int MAX_CLASS    = spq_pkg::MAX_CLASS_DEF,
	parameter int CLASS_DEPTH  = spq_pkg::CLASS_DEPTH_DEF,
	parameter int HANDLE_WIDTH = spq_pkg::HANDLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [spq_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // flow_id[15:0], pkt_handle[31:16]
	input  logic                          s_tuser,   // req_type[0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [23:0]                   m_tdata,   // out_handle[15:0], out_class[18:16]
	output logic [spq_pkg::STATUS_W-1:0]  m_tuser    // status[2:0]
);

	localparam int CW    = $clog2(MAX_CLASS + 1);
	localparam int PTR_W = $clog2(CLASS_DEPTH);
	localparam int AW    = CW + PTR_W;
	localparam int SW    = (HANDLE_WIDTH < spq_pkg::HDL_W) ? HANDLE_WIDTH : spq_pkg::HDL_W;

	logic                        valid_s1;
	logic                        req_s1;
	logic [spq_pkg::FLOW_W-1:0]  flow_s1;
	logic [SW-1:0]               hdl_s1;

	logic                        valid_s2;
	spq_pkg::dec_t               dec_s2;
	logic [SW-1:0]               hdl_s2;

	logic                        fire;
	logic                        accept;
	spq_pkg::dec_t               dec;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [SW-1:0]               mem_wdata;
	logic [AW-1:0]               mem_raddr;
	logic [SW-1:0]               mem_rdata;
	logic [spq_pkg::HDL_W-1:0]   out_handle;

	// Handshake: the request in the input register is decided when the result
	// register is free or being emptied.
	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign accept   = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= s_tuser;
			flow_s1 <= s_tdata[15:0];
			hdl_s1  <= SW'(s_tdata[31:16]);
		end
	end

	spq_ctrl #(
		.MAX_CLASS   (MAX_CLASS),
		.CLASS_DEPTH (CLASS_DEPTH),
		.SW          (SW),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.req_type  (req_s1),
		.flow_id   (flow_s1),
		.handle    (hdl_s1),
		.dec       (dec),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr)
	);

	spq_store #(
		.AW (AW),
		.DW (SW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (fire),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dec_s2 <= dec;
			hdl_s2 <= hdl_s1;
		end
	end

	// Reported handle: the dropped arrival, the handle read from the store,
	// or zero.
	always_comb begin
		case (dec_s2.hsel)
			spq_pkg::HS_ARRIVAL: out_handle = spq_pkg::HDL_W'(hdl_s2);
			spq_pkg::HS_STORE:   out_handle = spq_pkg::HDL_W'(mem_rdata);
			default:             out_handle = '0;
		endcase
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = dec_s2.status;
	assign m_tdata  = {5'b0, dec_s2.cls, out_handle};

endmodule

FILE: design/spq_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow id classifier
// Maps a flow id to a traffic class: the id itself below one thousand, the
// id divided by one thousand above, and class 0 when out of range.
// ----------------------------------------------------------------------------
module spq_classify #(
	parameter int MAX_CLASS = spq_pkg::MAX_CLASS_DEF
) (
	input  logic [spq_pkg::FLOW_W-1:0]          flow_id,
	input  logic [$clog2(MAX_CLASS+1)-1:0]      nc,
	output logic [$clog2(MAX_CLASS+1)-1:0]      cls
);

	localparam int CW       = $clog2(MAX_CLASS + 1);
	localparam int OVER_LIM = (MAX_CLASS + 1) * spq_pkg::ID_DIV;

	logic [CW-1:0] div_cnt;
	logic          over;
	logic          low_id;
	logic          in_range;

	// Quotient by one thousand, counted with independent threshold compares.
	always_comb begin
		div_cnt = '0;
		for (int t = 1; t <= MAX_CLASS; t++) begin
			if (32'(flow_id) >= 32'(t * spq_pkg::ID_DIV)) begin
				div_cnt = div_cnt + CW'(1);
			end
		end
	end

	assign over   = 32'(flow_id) >= 32'(OVER_LIM);
	assign low_id = 32'(flow_id) <= 32'(spq_pkg::ID_SPLIT);

	// A class of 0 or above the classes in use falls back to class 0.
	always_comb begin
		if (low_id) begin
			in_range = (flow_id != '0) && (flow_id <= spq_pkg::FLOW_W'(nc));
		end else begin
			in_range = !over && (div_cnt <= nc);
		end
	end

	always_comb begin
		if (!in_range) begin
			cls = '0;
		end else if (low_id) begin
			cls = flow_id[CW-1:0];
		end else begin
			cls = div_cnt;
		end
	end

endmodule

FILE: design/spq_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor store
// Handle memory with one write port and one registered read port. Each class
// owns a ring of entries addressed by class and ring position.
// ----------------------------------------------------------------------------
module spq_store #(
	parameter int AW = 9,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1 << AW)-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/spq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue controller
// Holds the configuration, the per-class ring heads and counts and the total
// occupancy, decides the outcome of each request and drives the store ports.
// ----------------------------------------------------------------------------
module spq_ctrl #(
	parameter int MAX_CLASS   = spq_pkg::MAX_CLASS_DEF,
	parameter int CLASS_DEPTH = spq_pkg::CLASS_DEPTH_DEF,
	parameter int SW          = spq_pkg::HANDLE_WIDTH_DEF,
	parameter int AW          = $clog2(MAX_CLASS + 1) + $clog2(CLASS_DEPTH)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_addr,
	input  logic [spq_pkg::LIMIT_W-1:0]         cfg_wdata,
	input  logic                                fire,
	input  logic                                req_type,
	input  logic [spq_pkg::FLOW_W-1:0]          flow_id,
	input  logic [SW-1:0]                       handle,
	output spq_pkg::dec_t                       dec,
	output logic                                mem_we,
	output logic [AW-1:0]                       mem_waddr,
	output logic [SW-1:0]                       mem_wdata,
	output logic [AW-1:0]                       mem_raddr
);

	localparam int CW    = $clog2(MAX_CLASS + 1);
	localparam int PTR_W = $clog2(CLASS_DEPTH);
	localparam int CNT_W = $clog2(CLASS_DEPTH + 1);
	localparam int NSLOT = MAX_CLASS + 1;

	logic [spq_pkg::NCLS_W-1:0]  num_classes_q;
	logic [spq_pkg::LIMIT_W-1:0] queue_limit_q;
	logic [PTR_W-1:0]            head_q  [0:NSLOT-1];
	logic [CNT_W-1:0]            count_q [0:NSLOT-1];
	logic [spq_pkg::TOTAL_W-1:0] total_q;

	logic [CW-1:0] nc;
	logic [CW-1:0] cls;
	logic [CW-1:0] srv;
	logic          srv_found;
	logic [CW-1:0] vic;
	logic          vic_found;
	logic          ring_full;
	logic          room;

	logic          push_en;
	logic [CW-1:0] push_cls;
	logic          pop_en;
	logic          pop_head;
	logic [CW-1:0] pop_cls;

	// Ring position of an offset from a class head.
	function automatic logic [PTR_W-1:0] ring_pos(input logic [PTR_W-1:0] hd,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(hd) + (CNT_W + 1)'(off);
		if (s >= (CNT_W + 1)'(CLASS_DEPTH)) begin
			s = s - (CNT_W + 1)'(CLASS_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	// Classes in use, capped at the largest class.
	assign nc = (int'(num_classes_q) > MAX_CLASS) ? CW'(MAX_CLASS) : CW'(num_classes_q);

	spq_classify #(
		.MAX_CLASS (MAX_CLASS)
	) u_classify (
		.flow_id (flow_id),
		.nc      (nc),
		.cls     (cls)
	);

	// Dequeue service order: the lowest nonempty class from 1 up, then class 0.
	always_comb begin
		srv       = '0;
		srv_found = 1'b0;
		for (int i = MAX_CLASS; i >= 1; i--) begin
			if (CW'(i) <= nc && count_q[i] != '0) begin
				srv       = CW'(i);
				srv_found = 1'b1;
			end
		end
		if (!srv_found && count_q[0] != '0) begin
			srv_found = 1'b1;
		end
	end

	// Push-out victim: class 0 if nonempty, else the highest nonempty class
	// between the arrival's class and the classes in use.
	always_comb begin
		vic       = '0;
		vic_found = 1'b0;
		for (int i = 1; i <= MAX_CLASS; i++) begin
			if (CW'(i) > cls && CW'(i) <= nc && count_q[i] != '0) begin
				vic       = CW'(i);
				vic_found = 1'b1;
			end
		end
		if (count_q[0] != '0) begin
			vic       = '0;
			vic_found = 1'b1;
		end
	end

	assign ring_full = count_q[cls] >= CNT_W'(CLASS_DEPTH);
	assign room      = ({1'b0, total_q} + 8'd1) < {1'b0, queue_limit_q};

	// Request decision.
	always_comb begin
		dec.status = spq_pkg::ST_EMPTY;
		dec.hsel   = spq_pkg::HS_ZERO;
		dec.cls    = '0;
		push_en    = 1'b0;
		push_cls   = cls;
		pop_en     = 1'b0;
		pop_head   = 1'b0;
		pop_cls    = srv;
		if (req_type == spq_pkg::REQ_DEQUEUE) begin
			if (srv_found) begin
				dec.status = spq_pkg::ST_DEQUEUED;
				dec.hsel   = spq_pkg::HS_STORE;
				dec.cls    = spq_pkg::CLS_W'(srv);
				pop_en     = 1'b1;
				pop_head   = 1'b1;
			end
		end else begin
			dec.cls = spq_pkg::CLS_W'(cls);
			if (ring_full) begin
				dec.status = spq_pkg::ST_DROPPED;
				dec.hsel   = spq_pkg::HS_ARRIVAL;
			end else if (room) begin
				dec.status = spq_pkg::ST_ENQUEUED;
				push_en    = 1'b1;
			end else if (cls == '0 || !vic_found) begin
				dec.status = spq_pkg::ST_DROPPED;
				dec.hsel   = spq_pkg::HS_ARRIVAL;
			end else begin
				dec.status = spq_pkg::ST_PUSHOUT;
				dec.hsel   = spq_pkg::HS_STORE;
				dec.cls    = spq_pkg::CLS_W'(vic);
				push_en    = 1'b1;
				pop_en     = 1'b1;
				pop_cls    = vic;
			end
		end
	end

	// Store accesses: write at the tail of the arrival's class, read at the
	// head of the served class or the tail of the victim class.
	assign mem_we    = fire && push_en;
	assign mem_waddr = {push_cls, ring_pos(head_q[push_cls], count_q[push_cls])};
	assign mem_wdata = handle;
	assign mem_raddr = pop_head ? {pop_cls, head_q[pop_cls]}
		: {pop_cls, ring_pos(head_q[pop_cls], count_q[pop_cls] - CNT_W'(1))};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= spq_pkg::NUM_CLASSES_RST;
			queue_limit_q <= spq_pkg::QUEUE_LIMIT_RST;
		end else if (cfg_we) begin
			if (cfg_addr == spq_pkg::CFG_NUM_CLASSES) begin
				num_classes_q <= cfg_wdata[spq_pkg::NCLS_W-1:0];
			end else begin
				queue_limit_q <= cfg_wdata;
			end
		end
	end

	// Ring heads, class counts and total occupancy. A write of the class count
	// register empties every queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			total_q <= '0;
		end else if (cfg_we && cfg_addr == spq_pkg::CFG_NUM_CLASSES) begin
			for (int i = 0; i < NSLOT; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
			total_q <= '0;
		end else if (fire) begin
			if (push_en) begin
				count_q[push_cls] <= count_q[push_cls] + CNT_W'(1);
			end
			if (pop_en) begin
				count_q[pop_cls] <= count_q[pop_cls] - CNT_W'(1);
			end
			if (pop_head) begin
				if (head_q[pop_cls] == PTR_W'(CLASS_DEPTH - 1)) begin
					head_q[pop_cls] <= '0;
				end else begin
					head_q[pop_cls] <= head_q[pop_cls] + PTR_W'(1);
				end
			end
			if (push_en && !pop_en) begin
				total_q <= total_q + spq_pkg::TOTAL_W'(1);
			end else if (pop_en && !push_en) begin
				total_q <= total_q - spq_pkg::TOTAL_W'(1);
			end
		end
	end

endmodule
